### hdl/hket_pkg.sv
// Shared widths, function codes and controller/datapath bundles for the exact tour solver.
package hket_pkg;

   localparam int FUNC_BITS    = 2;
   localparam int SLOT_BITS    = 4;
   localparam int NODE_ID_BITS = 20;
   localparam int DIST_BITS    = 32;
   localparam int LEN_BITS     = 36;
   localparam int COUNT_BITS   = 6;
   localparam int POS_BITS     = 4;

   // Input function codes.
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD_ID   = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD_DIST = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_SOLVE     = 2'd2;
   // Unused code: the block takes the beat and does nothing.
   localparam logic [FUNC_BITS-1:0] FUNC_RESERVED  = 2'd3;

   // Configuration register indexes.
   localparam logic REG_NODE_COUNT = 1'b0;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 id_wr;
      logic                 dist_wr;
      logic [SLOT_BITS-1:0] rd_a;
      logic [SLOT_BITS-1:0] rd_b;
      logic                 init_wr;
      logic                 node_wr;
      logic                 scan_clr;
      logic                 scan_acc;
      logic [SLOT_BITS-1:0] scan_i;
      logic                 fin_latch;
      logic                 order_wr;
      logic [POS_BITS-1:0]  order_pos;
      logic [SLOT_BITS-1:0] order_val;
      logic                 out_load;
      logic                 out_spec;
      logic                 out_found;
      logic [POS_BITS-1:0]  out_pos;
      logic                 out_last;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [SLOT_BITS-1:0] best_par;
      logic [SLOT_BITS-1:0] parent_q;
      logic                 out_free;
   } status_type;

endpackage

### hdl/hket_if.sv
// Valid/ready channel interfaces for request and result beats.
interface hket_req_if;
   logic                               valid;
   logic                               ready;
   logic [hket_pkg::FUNC_BITS-1:0]     func;
   logic [hket_pkg::SLOT_BITS-1:0]     slot_a;
   logic [hket_pkg::SLOT_BITS-1:0]     slot_b;
   logic [hket_pkg::NODE_ID_BITS-1:0]  node_id;
   logic [hket_pkg::DIST_BITS-1:0]     distance;
   modport source (output valid, func, slot_a, slot_b, node_id, distance, input ready);
   modport sink   (input valid, func, slot_a, slot_b, node_id, distance, output ready);
endinterface

interface hket_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [hket_pkg::POS_BITS-1:0]      position;
   logic [hket_pkg::NODE_ID_BITS-1:0]  tour_node;
   logic                               has_node;
   logic [hket_pkg::LEN_BITS-1:0]      tour_length;
   logic                               found;
   logic                               last;
   modport source (output valid, position, tour_node, has_node, tour_length, found, last,
                   input ready);
   modport sink   (input valid, position, tour_node, has_node, tour_length, found, last,
                   output ready);
endinterface

### hdl/hket_dp.sv
// Datapath: distance, cost and parent memories, candidate compare, tour order and result register.
module hket_dp #(
   parameter int MAX_NODES = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hket_pkg::cmd_type                   cmd,
   input  logic [MAX_NODES+2:0]                mem_rd_addr,
   input  logic [MAX_NODES+2:0]                mem_wr_addr,
   input  logic [hket_pkg::SLOT_BITS-1:0]      req_slot_a,
   input  logic [hket_pkg::SLOT_BITS-1:0]      req_slot_b,
   input  logic [hket_pkg::NODE_ID_BITS-1:0]   req_node_id,
   input  logic [hket_pkg::DIST_BITS-1:0]      req_distance,
   input  logic                                rsp_ready,
   output hket_pkg::status_type                status,
   output logic                                rsp_valid,
   output logic [hket_pkg::POS_BITS-1:0]       rsp_position,
   output logic [hket_pkg::NODE_ID_BITS-1:0]   rsp_tour_node,
   output logic                                rsp_has_node,
   output logic [hket_pkg::LEN_BITS-1:0]       rsp_tour_length,
   output logic                                rsp_found,
   output logic                                rsp_last
);
   localparam int AW = MAX_NODES + 3;
   localparam int DA = $clog2(MAX_NODES * MAX_NODES);
   localparam int OW = $clog2(MAX_NODES);
   localparam int SB = hket_pkg::SLOT_BITS;

   logic [hket_pkg::DIST_BITS-1:0]    dist_mem [MAX_NODES*MAX_NODES];
   logic [hket_pkg::LEN_BITS-1:0]     cost_mem [2**AW];
   logic [SB-1:0]                     parent_mem [2**AW];
   logic [hket_pkg::NODE_ID_BITS-1:0] id_ff [2**SB];
   logic [SB-1:0]                     order_ff [MAX_NODES];

   logic [hket_pkg::DIST_BITS-1:0] dist_q_ff;
   logic [hket_pkg::LEN_BITS-1:0]  cost_q_ff;
   logic [SB-1:0]                  parent_q_ff;
   logic [hket_pkg::LEN_BITS-1:0]  best_ff;
   logic [SB-1:0]                  best_par_ff;
   logic                           got_ff;
   logic [hket_pkg::LEN_BITS-1:0]  len_ff;

   logic [7:0] wr_lo, wr_hi, rd_lo, rd_hi;
   logic [DA-1:0] dist_wr_idx, dist_rd_idx;
   logic [hket_pkg::LEN_BITS-1:0] cand;
   logic [hket_pkg::LEN_BITS-1:0] cost_wdata;
   logic [SB-1:0] out_slot;

   // Pair distances are symmetric, so each pair is kept once under its ordered index.
   always_comb begin
      wr_lo = 8'((req_slot_a < req_slot_b) ? req_slot_a : req_slot_b);
      wr_hi = 8'((req_slot_a < req_slot_b) ? req_slot_b : req_slot_a);
      rd_lo = 8'((cmd.rd_a < cmd.rd_b) ? cmd.rd_a : cmd.rd_b);
      rd_hi = 8'((cmd.rd_a < cmd.rd_b) ? cmd.rd_b : cmd.rd_a);
      dist_wr_idx = DA'(wr_lo * 8'(MAX_NODES) + wr_hi);
      dist_rd_idx = DA'(rd_lo * 8'(MAX_NODES) + rd_hi);
   end

   always_ff @(posedge clock) begin
      if (cmd.dist_wr) begin
         dist_mem[dist_wr_idx] <= req_distance;
      end
      dist_q_ff <= dist_mem[dist_rd_idx];
   end

   // Subset cost and parent memories, addressed by subset and end node.
   assign cost_wdata = cmd.init_wr ? hket_pkg::LEN_BITS'(dist_q_ff) : best_ff;

   always_ff @(posedge clock) begin
      if (cmd.init_wr || cmd.node_wr) begin
         cost_mem[mem_wr_addr] <= cost_wdata;
      end
      if (cmd.node_wr) begin
         parent_mem[mem_wr_addr] <= best_par_ff;
      end
      cost_q_ff   <= cost_mem[mem_rd_addr];
      parent_q_ff <= parent_mem[mem_rd_addr];
   end

   // Candidate compare: strict less-than keeps the lowest index on ties.
   assign cand = cost_q_ff + hket_pkg::LEN_BITS'(dist_q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         got_ff <= 1'b0;
      end else if (cmd.scan_clr) begin
         got_ff <= 1'b0;
      end else if (cmd.scan_acc) begin
         got_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         best_ff     <= '0;
         best_par_ff <= '0;
      end else if (cmd.scan_acc && (!got_ff || cand < best_ff)) begin
         best_ff     <= cand;
         best_par_ff <= cmd.scan_i;
      end
      if (cmd.fin_latch) begin
         len_ff <= best_ff;
      end
   end

   // Node ids per slot and the recovered tour order.
   always_ff @(posedge clock) begin
      if (cmd.id_wr) begin
         id_ff[req_slot_a] <= req_node_id;
      end
      if (cmd.order_wr) begin
         order_ff[cmd.order_pos[OW-1:0]] <= cmd.order_val;
      end
   end

   // Result register: the next beat loads as soon as the current one is taken.
   assign out_slot = (cmd.out_pos == '0) ? '0 : order_ff[cmd.out_pos[OW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_spec) begin
            rsp_position    <= '0;
            rsp_tour_node   <= '0;
            rsp_has_node    <= 1'b0;
            rsp_tour_length <= '0;
            rsp_found       <= cmd.out_found;
            rsp_last        <= 1'b1;
         end else begin
            rsp_position    <= cmd.out_pos;
            rsp_tour_node   <= id_ff[out_slot];
            rsp_has_node    <= 1'b1;
            rsp_tour_length <= len_ff;
            rsp_found       <= 1'b1;
            rsp_last        <= cmd.out_last;
         end
      end
   end

   assign status.best_par = best_par_ff;
   assign status.parent_q = parent_q_ff;
   assign status.out_free = !rsp_valid || rsp_ready;

endmodule

### hdl/hket_ctrl.sv
// Controller: sequences loads, the subset sweep, the backtrack and the result beats.
module hket_ctrl #(
   parameter int MAX_NODES = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic [hket_pkg::FUNC_BITS-1:0]      req_func,
   input  logic [hket_pkg::SLOT_BITS-1:0]      req_slot_a,
   input  logic [hket_pkg::SLOT_BITS-1:0]      req_slot_b,
   input  logic [hket_pkg::COUNT_BITS-1:0]     node_count,
   input  hket_pkg::status_type                status,
   output logic                                req_ready,
   output hket_pkg::cmd_type                   cmd,
   output logic [MAX_NODES+2:0]                mem_rd_addr,
   output logic [MAX_NODES+2:0]                mem_wr_addr
);
   localparam int MW = MAX_NODES - 1;
   localparam int SB = hket_pkg::SLOT_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT_RD, ST_INIT_WR, ST_JSEL, ST_SCAN_RD, ST_SCAN_ACC,
      ST_SCAN_WR, ST_BK_RD, ST_BK_WAIT, ST_OUT, ST_SPEC
   } state_type;

   state_type             state_ff;
   logic [MW:0]           mask_ff;
   logic [MW-1:0]         prev_ff;
   logic [SB-1:0]         j_ff;
   logic [SB-1:0]         i_ff;
   logic [SB-1:0]         m_ff;
   logic [hket_pkg::POS_BITS-1:0] pos_ff;
   logic                  fin_ff;

   logic          accept;
   logic [MW:0]   total;
   logic [MW-1:0] full;
   logic [MW-1:0] mask_lo;
   logic [MW-1:0] onehot_j;
   logic [MW-1:0] onehot_i;
   logic [MW-1:0] drop_j;
   logic          bit_j;
   logic          bit_i;
   logic          pair_ok;
   logic          bad_count;

   // Loop bounds and subset bit tests.
   always_comb begin
      total     = (MW+1)'(1) << m_ff;
      full      = MW'(total - (MW+1)'(1));
      mask_lo   = mask_ff[MW-1:0];
      onehot_j  = MW'(1) << j_ff;
      onehot_i  = MW'(1) << i_ff;
      drop_j    = mask_lo ^ onehot_j;
      bit_j     = |(mask_lo & onehot_j);
      bit_i     = |(prev_ff & onehot_i);
      accept    = req_valid && req_ready;
      pair_ok   = (32'(req_slot_a) < 32'(MAX_NODES)) && (32'(req_slot_b) < 32'(MAX_NODES));
      bad_count = (node_count == '0) || (32'(node_count) > 32'(MAX_NODES));
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Commands follow the state and the loop counters.
   always_comb begin
      cmd          = '0;
      mem_rd_addr  = {prev_ff, i_ff};
      mem_wr_addr  = {mask_lo, j_ff};
      cmd.scan_i   = i_ff;
      cmd.order_pos = pos_ff;
      cmd.order_val = i_ff + SB'(1);
      cmd.out_pos  = pos_ff;
      cmd.out_last = (pos_ff == m_ff);
      cmd.out_found = (node_count == '0);
      case (state_ff)
         ST_IDLE: begin
            cmd.id_wr   = accept && (req_func == hket_pkg::FUNC_LOAD_ID);
            cmd.dist_wr = accept && (req_func == hket_pkg::FUNC_LOAD_DIST) && pair_ok;
         end
         ST_INIT_RD: begin
            cmd.rd_a = '0;
            cmd.rd_b = j_ff + SB'(1);
         end
         ST_INIT_WR: begin
            cmd.init_wr = 1'b1;
            mem_wr_addr = {onehot_j, j_ff};
         end
         ST_JSEL: begin
            cmd.scan_clr = (mask_ff == total) ||
                           ((j_ff != m_ff) && bit_j && (drop_j != '0));
         end
         ST_SCAN_RD: begin
            cmd.rd_a = i_ff + SB'(1);
            cmd.rd_b = fin_ff ? '0 : j_ff + SB'(1);
         end
         ST_SCAN_ACC: begin
            cmd.scan_acc = 1'b1;
         end
         ST_SCAN_WR: begin
            cmd.fin_latch = fin_ff;
            cmd.node_wr   = !fin_ff;
         end
         ST_BK_RD: begin
            cmd.order_wr = (pos_ff != '0);
         end
         ST_BK_WAIT: begin
            cmd.order_wr = 1'b0;
         end
         ST_OUT: begin
            cmd.out_load = status.out_free;
         end
         ST_SPEC: begin
            cmd.out_load = status.out_free;
            cmd.out_spec = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Sequencer state and loop counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mask_ff  <= '0;
         prev_ff  <= '0;
         j_ff     <= '0;
         i_ff     <= '0;
         m_ff     <= '0;
         pos_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_func == hket_pkg::FUNC_SOLVE)) begin
                  if (bad_count) begin
                     state_ff <= ST_SPEC;
                  end else begin
                     m_ff     <= SB'(node_count - hket_pkg::COUNT_BITS'(1));
                     j_ff     <= '0;
                     state_ff <= ST_INIT_RD;
                  end
               end
            end
            ST_INIT_RD: begin
               if (j_ff == m_ff) begin
                  mask_ff  <= (MW+1)'(1);
                  j_ff     <= '0;
                  fin_ff   <= 1'b0;
                  state_ff <= ST_JSEL;
               end else begin
                  state_ff <= ST_INIT_WR;
               end
            end
            ST_INIT_WR: begin
               j_ff     <= j_ff + SB'(1);
               state_ff <= ST_INIT_RD;
            end
            ST_JSEL: begin
               if (mask_ff == total) begin
                  fin_ff   <= 1'b1;
                  prev_ff  <= full;
                  i_ff     <= '0;
                  state_ff <= ST_SCAN_RD;
               end else if (j_ff == m_ff) begin
                  mask_ff <= mask_ff + (MW+1)'(1);
                  j_ff    <= '0;
               end else if (!bit_j || (drop_j == '0)) begin
                  j_ff <= j_ff + SB'(1);
               end else begin
                  prev_ff  <= drop_j;
                  i_ff     <= '0;
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_SCAN_RD: begin
               if (i_ff == m_ff) begin
                  state_ff <= ST_SCAN_WR;
               end else if (bit_i) begin
                  state_ff <= ST_SCAN_ACC;
               end else begin
                  i_ff <= i_ff + SB'(1);
               end
            end
            ST_SCAN_ACC: begin
               i_ff     <= i_ff + SB'(1);
               state_ff <= ST_SCAN_RD;
            end
            ST_SCAN_WR: begin
               if (fin_ff) begin
                  i_ff     <= status.best_par;
                  prev_ff  <= full;
                  pos_ff   <= m_ff;
                  state_ff <= ST_BK_RD;
               end else begin
                  j_ff     <= j_ff + SB'(1);
                  state_ff <= ST_JSEL;
               end
            end
            ST_BK_RD: begin
               if (pos_ff == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  prev_ff  <= prev_ff ^ onehot_i;
                  state_ff <= ST_BK_WAIT;
               end
            end
            ST_BK_WAIT: begin
               i_ff     <= (status.parent_q >= m_ff) ? '0 : status.parent_q;
               pos_ff   <= pos_ff - hket_pkg::POS_BITS'(1);
               state_ff <= ST_BK_RD;
            end
            ST_OUT: begin
               if (status.out_free) begin
                  if (pos_ff == m_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     pos_ff <= pos_ff + hket_pkg::POS_BITS'(1);
                  end
               end
            end
            ST_SPEC: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hdl/held_karp_exact_tour_top.sv
// Top level of the exact shortest closed tour solver: channels, register port and wiring.
//
// Load beats (node id per slot, symmetric pair distance) are taken one per cycle while the
// block is idle. A solve beat over k = node_count slots (k-1 = m) holds the request side
// until the sweep, the backtrack and the result beats are done. The start cost of each end
// node is read from the distance memory and written to the cost memory. The sweep then
// visits each of the 2^m - 1 subsets in the selection state, and for each end node of a
// subset of two or more nodes it scans every node of its predecessor subset, scoring each
// predecessor candidate through registered memory reads. A closing scan completes the
// tour and the backtrack recovers its order. The k result beats then follow at up to one
// per cycle as the result side takes them. An empty set or a count beyond MAX_NODES gives
// one result beat. The cost and parent memories hold 2^(MAX_NODES+3) entries each and need
// no clearing after reset; node_count must only be written while no solve is in flight.
module held_karp_exact_tour_top #(
   parameter int MAX_NODES = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   hket_req_if.sink                            req,
   hket_rsp_if.source                          rsp,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   logic [hket_pkg::COUNT_BITS-1:0] node_count_ff;
   hket_pkg::cmd_type               cmd;
   hket_pkg::status_type            status;
   logic [MAX_NODES+2:0]            mem_rd_addr;
   logic [MAX_NODES+2:0]            mem_wr_addr;

   // Register port: writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == hket_pkg::REG_NODE_COUNT) ? 32'(node_count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == hket_pkg::REG_NODE_COUNT)) begin
         node_count_ff <= csr_pwdata[hket_pkg::COUNT_BITS-1:0];
      end
   end

   hket_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_func    (req.func),
      .req_slot_a  (req.slot_a),
      .req_slot_b  (req.slot_b),
      .node_count  (node_count_ff),
      .status      (status),
      .req_ready   (req.ready),
      .cmd         (cmd),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr)
   );

   hket_dp #(.MAX_NODES(MAX_NODES)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .mem_rd_addr     (mem_rd_addr),
      .mem_wr_addr     (mem_wr_addr),
      .req_slot_a      (req.slot_a),
      .req_slot_b      (req.slot_b),
      .req_node_id     (req.node_id),
      .req_distance    (req.distance),
      .rsp_ready       (rsp.ready),
      .status          (status),
      .rsp_valid       (rsp.valid),
      .rsp_position    (rsp.position),
      .rsp_tour_node   (rsp.tour_node),
      .rsp_has_node    (rsp.has_node),
      .rsp_tour_length (rsp.tour_length),
      .rsp_found       (rsp.found),
      .rsp_last        (rsp.last)
   );

endmodule
